// ===== rtl/hff_pkg.sv =====
// ----------------------------------------------------------------------------
// hff_pkg
// Shared constants, types and helpers of the hex field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package hff_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int LEN_W     = $clog2(MAX_WIDTH + 1);
	localparam int VAL_W     = 32;
	localparam int SPEC_W    = 7;
	localparam int NDIG_W    = 4;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_UPPER = 8'd65;
	localparam logic [7:0] CH_LOWER = 8'd97;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic setup;
		logic emit;
	} hff_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic emit_last;
		logic slot_free;
	} hff_status_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [SPEC_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (LEN_W'(v) > LEN_W'(MAX_WIDTH) || SPEC_W > LEN_W && v > SPEC_W'(MAX_WIDTH)) begin
			r = LEN_W'(MAX_WIDTH);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] r;
		if (nib <= 4'd9) begin
			r = CH_ZERO + 8'(nib);
		end else begin
			r = (upper ? CH_UPPER : CH_LOWER) + 8'(nib) - 8'd10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hff_ctrl.sv =====
// ----------------------------------------------------------------------------
// hff_ctrl
// Controller: takes a conversion, sets it up, then steps out characters.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  hff_pkg::hff_status_t status,
	output hff_pkg::hff_cmd_t    cmd
);
	import hff_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					state_q <= status.empty ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (status.slot_free && status.emit_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.setup = (state_q == ST_SETUP);
		cmd.emit  = (state_q == ST_EMIT) && status.slot_free;
	end

endmodule

`default_nettype wire

// ===== rtl/hff_dpath.sv =====
// ----------------------------------------------------------------------------
// hff_dpath
// Datapath: item registers, field layout, character select, output register
// and the running character total.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_dpath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  hff_pkg::hff_cmd_t                cmd,
	output hff_pkg::hff_status_t             status,
	input  wire  [hff_pkg::VAL_W-1:0]        hex_value,
	input  wire  [hff_pkg::SPEC_W-1:0]       field_width,
	input  wire  [hff_pkg::SPEC_W-1:0]       precision,
	input  wire                              has_precision,
	input  wire                              left_justify,
	input  wire                              zero_pad,
	input  wire                              upper_case,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [7:0]                       out_char,
	output logic                             last,
	output logic [31:0]                      printed_total
);
	import hff_pkg::*;

	logic [VAL_W-1:0]  val_q;
	logic [LEN_W-1:0]  width_q;
	logic [LEN_W-1:0]  prec_q;
	logic              dot_q;
	logic              minus_q;
	logic              zero_q;
	logic              upper_q;

	logic [NDIG_W-1:0] ndig_q;
	logic [LEN_W-1:0]  nbody_q;
	logic [LEN_W-1:0]  pad_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        padch_q;
	logic [LEN_W-1:0]  pos_q;

	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              last_q;
	logic [31:0]       char_total_q;

	logic [NDIG_W-1:0] ndig_c;
	logic [LEN_W-1:0]  nbody_c;
	logic [LEN_W-1:0]  pad_c;
	logic [LEN_W-1:0]  len_c;

	logic              in_body;
	logic [LEN_W-1:0]  body_pos;
	logic [LEN_W-1:0]  nib_idx;
	logic [3:0]        nib;
	logic [7:0]        char_c;

	// Field layout from the stored item.
	always_comb begin
		ndig_c = '0;
		for (int n = 0; n < VAL_W / 4; n++) begin
			if (val_q[n*4 +: 4] != 4'd0) ndig_c = NDIG_W'(n + 1);
		end
		if (val_q == '0) begin
			ndig_c = (dot_q && prec_q == '0) ? NDIG_W'(0) : NDIG_W'(1);
		end
		nbody_c = (dot_q && prec_q > LEN_W'(ndig_c)) ? prec_q : LEN_W'(ndig_c);
		pad_c   = (width_q > nbody_c) ? width_q - nbody_c : '0;
		len_c   = pad_c + nbody_c;
	end

	// Character at the current position of the field.
	always_comb begin
		if (!minus_q) begin
			in_body  = (pos_q >= pad_q);
			body_pos = pos_q - pad_q;
		end else begin
			in_body  = (pos_q < nbody_q);
			body_pos = pos_q;
		end
		// Digits sit at the right end of the body, most significant first.
		nib_idx = nbody_q - LEN_W'(1) - body_pos;
		nib     = val_q[nib_idx[2:0]*4 +: 4];
		if (!in_body) begin
			char_c = padch_q;
		end else if (nib_idx < LEN_W'(ndig_q)) begin
			char_c = hex_char(nib, upper_q);
		end else begin
			char_c = CH_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= hex_value;
			width_q <= sat_len(field_width);
			prec_q  <= sat_len(precision);
			dot_q   <= has_precision;
			minus_q <= left_justify;
			zero_q  <= zero_pad;
			upper_q <= upper_case;
		end
		if (cmd.setup) begin
			ndig_q  <= ndig_c;
			nbody_q <= nbody_c;
			pad_q   <= pad_c;
			len_q   <= len_c;
			padch_q <= (!minus_q && zero_q && !dot_q) ? CH_ZERO : CH_SPACE;
			pos_q   <= '0;
		end else if (cmd.emit) begin
			pos_q   <= pos_q + LEN_W'(1);
		end
		if (cmd.emit) begin
			out_char_q <= char_c;
			last_q     <= status.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			char_total_q <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid_q  <= 1'b1;
				char_total_q <= char_total_q + 32'd1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_comb begin
		status.empty     = (len_c == '0);
		status.emit_last = (pos_q == len_q - LEN_W'(1));
		status.slot_free = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign last          = last_q;
	assign printed_total = char_total_q;

endmodule

`default_nettype wire

// ===== rtl/hex_field_formatter.sv =====
// ----------------------------------------------------------------------------
// hex_field_formatter
// Formats one 32-bit value as a printf-style hex field, one character per
// output transaction.
// ----------------------------------------------------------------------------
// A conversion is accepted only while the block is idle. It then passes a
// setup state and emits the field (at most MAX_WIDTH characters) at one
// character per cycle while the output side does not stall; the single
// character register at the output sets this pace. An empty field (value 0,
// precision 0 given, width 0) produces nothing. printed_total counts all
// characters since reset and wraps at 2^32.
`default_nettype none

module hex_field_formatter (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [31:0] hex_value,
	input  wire [6:0]  field_width,
	input  wire [6:0]  precision,
	input  wire        has_precision,
	input  wire        left_justify,
	input  wire        zero_pad,
	input  wire        upper_case,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_char,
	output logic       last,
	output logic [31:0] printed_total
);
	import hff_pkg::*;

	hff_cmd_t    cmd;
	hff_status_t status;

	hff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	hff_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.hex_value     (hex_value),
		.field_width   (field_width),
		.precision     (precision),
		.has_precision (has_precision),
		.left_justify  (left_justify),
		.zero_pad      (zero_pad),
		.upper_case    (upper_case),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.last          (last),
		.printed_total (printed_total)
	);

	// Within a field, the next character is ready right after one is taken.
	a_field_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("character stream broke inside a field");

	// Consecutive characters of a field carry consecutive totals.
	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> printed_total == $past(printed_total) + 32'd1)
		else $error("running total did not advance by one");

	// A new conversion is never taken back to back with another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a conversion is in progress");

endmodule

`default_nettype wire

// ===== sim/hex_field_formatter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_field_formatter_tb
// Self-checking testbench of the hex field formatter. Each accepted
// conversion is expanded into its expected characters. Every output
// transaction is checked against the oldest of them, including its last flag
// and running total. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------

class hex_char_board;

	typedef struct {
		logic [7:0]  ch;
		logic        last;
		logic [31:0] total;
	} exp_char_t;

	exp_char_t   expected_chars[$];
	logic [31:0] char_count;
	int          mismatches;

	function new();
		char_count = '0;
		mismatches = 0;
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction

	function void add_char(input logic [7:0] ch, input int k, input int field_len);
		exp_char_t e;
		char_count = char_count + 32'd1;
		e.ch    = ch;
		e.last  = (k == field_len - 1);
		e.total = char_count;
		expected_chars.push_back(e);
	endfunction

	// Expands one accepted conversion into the characters it must produce.
	function void note_conversion(input logic [31:0] val, input logic [6:0] wid,
			input logic [6:0] prec_in, input bit dot, input bit minus,
			input bit zero, input bit upper);
		int         width, prec, ndig, nbody, pad, field_len, k;
		logic [7:0] padch;
		logic [3:0] nib;
		width = (wid > hff_pkg::MAX_WIDTH) ? hff_pkg::MAX_WIDTH : int'(wid);
		prec  = (prec_in > hff_pkg::MAX_WIDTH) ? hff_pkg::MAX_WIDTH : int'(prec_in);
		ndig  = 0;
		if (val == 32'd0) begin
			ndig = (dot && prec == 0) ? 0 : 1;
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (val[4*i +: 4] != 4'd0) begin
					ndig = i + 1;
				end
			end
		end
		nbody     = (dot && prec > ndig) ? prec : ndig;
		pad       = (width > nbody) ? width - nbody : 0;
		padch     = (!minus && zero && !dot) ? hff_pkg::CH_ZERO : hff_pkg::CH_SPACE;
		field_len = pad + nbody;
		k         = 0;
		if (!minus) begin
			repeat (pad) begin
				add_char(padch, k, field_len);
				k++;
			end
		end
		repeat (nbody - ndig) begin
			add_char(hff_pkg::CH_ZERO, k, field_len);
			k++;
		end
		for (int i = ndig; i > 0; i--) begin
			nib = val[4*(i-1) +: 4];
			if (nib <= 4'd9) begin
				add_char(8'd48 + 8'(nib), k, field_len);
			end else begin
				add_char((upper ? 8'd65 : 8'd97) + 8'(nib) - 8'd10, k, field_len);
			end
			k++;
		end
		if (minus) begin
			repeat (pad) begin
				add_char(hff_pkg::CH_SPACE, k, field_len);
				k++;
			end
		end
	endfunction

	function void check_char(input logic [7:0] ch, input logic last_flag,
			input logic [31:0] total);
		exp_char_t e;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected character %h (last %b, total %0d)",
				$time, ch, last_flag, total);
			mismatches++;
			return;
		end
		e = expected_chars.pop_front();
		if (ch !== e.ch) begin
			$display("%0t: out_char expected %h actual %h", $time, e.ch, ch);
			mismatches++;
		end
		if (last_flag !== e.last) begin
			$display("%0t: last expected %b actual %b", $time, e.last, last_flag);
			mismatches++;
		end
		if (total !== e.total) begin
			$display("%0t: printed_total expected %0d actual %0d", $time, e.total, total);
			mismatches++;
		end
	endfunction

endclass

module hex_field_formatter_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] hex_value = '0;
	logic [6:0]  field_width = '0;
	logic [6:0]  precision = '0;
	logic        has_precision = 1'b0;
	logic        left_justify = 1'b0;
	logic        zero_pad = 1'b0;
	logic        upper_case = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_char;
	logic        last;
	logic [31:0] printed_total;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	hex_char_board board = new();

	hex_field_formatter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.hex_value     (hex_value),
		.field_width   (field_width),
		.precision     (precision),
		.has_precision (has_precision),
		.left_justify  (left_justify),
		.zero_pad      (zero_pad),
		.upper_case    (upper_case),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.last          (last),
		.printed_total (printed_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_char(out_char, last, printed_total);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task send_conv(input logic [31:0] val, input logic [6:0] wid, input logic [6:0] prec,
			input bit dot, input bit minus, input bit zero, input bit upper);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		hex_value     <= val;
		field_width   <= wid;
		precision     <= prec;
		has_precision <= dot;
		left_justify  <= minus;
		zero_pad      <= zero;
		upper_case    <= upper;
		do begin
			@(posedge clk);
		end while (!in_ready);
		board.note_conversion(hex_value, field_width, precision, has_precision,
			left_justify, zero_pad, upper_case);
		@(negedge clk);
	endtask

	task send_random_conv();
		logic [31:0] val;
		logic [6:0]  wid, prec;
		case ($urandom_range(9))
			0: val = 32'd0;
			1: val = 32'hFFFF_FFFF;
			2: val = $urandom;
			default: val = $urandom >> $urandom_range(31);
		endcase
		wid  = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(16));
		prec = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
		send_conv(val, wid, prec, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// The sender holds off until every expected character has come out.
	task drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed conversions, no idling.
		send_conv(32'd0,         7'd0,   7'd0,   0, 0, 0, 0);
		send_conv(32'd0,         7'd0,   7'd0,   1, 0, 0, 0);  // empty field
		send_conv(32'd0,         7'd5,   7'd0,   1, 0, 0, 0);
		send_conv(32'd0,         7'd5,   7'd0,   1, 1, 0, 0);
		send_conv(32'hFFFF_FFFF, 7'd0,   7'd0,   0, 0, 0, 0);
		send_conv(32'hFFFF_FFFF, 7'd0,   7'd0,   0, 0, 0, 1);
		send_conv(32'h1234_5678, 7'd12,  7'd0,   0, 1, 0, 0);
		send_conv(32'h00AB_CDEF, 7'd12,  7'd0,   0, 0, 1, 1);
		send_conv(32'h00AB_CDEF, 7'd12,  7'd10,  1, 0, 1, 0);  // precision beats zero pad
		send_conv(32'h00AB_CDEF, 7'd12,  7'd0,   0, 1, 1, 0);  // minus beats zero pad
		send_conv(32'h00AB_CDEF, 7'd0,   7'd40,  0, 0, 0, 0);  // precision ignored
		send_conv(32'h00AB_CDEF, 7'd0,   7'd3,   1, 0, 0, 0);
		send_conv(32'h0000_0001, 7'd1,   7'd1,   1, 0, 0, 0);
		send_conv(32'h8000_0000, 7'd9,   7'd0,   0, 0, 1, 0);
		send_conv(32'hDEAD_BEEF, 7'd127, 7'd0,   0, 0, 0, 1);  // width saturates
		send_conv(32'hDEAD_BEEF, 7'd0,   7'd127, 1, 0, 0, 0);  // precision saturates
		send_conv(32'h0000_0A5C, 7'd64,  7'd64,  1, 1, 1, 1);
		send_conv(32'h0000_0A5C, 7'd65,  7'd0,   0, 0, 1, 0);
		send_conv(32'd0,         7'd127, 7'd0,   1, 1, 0, 0);
		send_conv(32'd0,         7'd3,   7'd0,   0, 0, 1, 0);
		send_conv(32'hF,         7'd2,   7'd5,   1, 1, 0, 1);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			repeat (90) send_random_conv();
			drain();
		end

		in_valid <= 1'b0;
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
